// File: rtl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg: shared types and constants for the Bezier path evaluator
// Widths, codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package bpe_pkg;

	localparam int MAX_POINTS_DEF  = 64;
	localparam int STEPS_DEF       = 1000;
	localparam int COORD_WIDTH_DEF = 24;

	localparam int T_W      = 17;
	localparam int STEP_W   = 10;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 7;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_EVAL   = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_NOSEG  = 2'd2;

	localparam logic [0:0] REG_POINT_COUNT = 1'd0;
	localparam logic [0:0] REG_CLOSED      = 1'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_LATCH,
		S_RUN,
		S_DRAIN,
		S_DONE
	} state_t;

endpackage

// File: rtl/bpe_eval.sv
// ----------------------------------------------------------------------------
// bpe_eval: pipelined cubic Bernstein evaluator
// Weights from t, then coordinate products, then rounding and saturation.
// Five stages; one sample enters per cycle.
// ----------------------------------------------------------------------------
module bpe_eval #(
	parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [bpe_pkg::T_W-1:0]       t,
	input  logic signed [COORD_WIDTH-1:0] c0x, c1x, c2x, c3x,
	input  logic signed [COORD_WIDTH-1:0] c0y, c1y, c2y, c3y,
	output logic                          out_vld,
	output logic signed [COORD_WIDTH-1:0] px,
	output logic signed [COORD_WIDTH-1:0] py
);
	localparam int AW = COORD_WIDTH + 27;

	logic [4:0] vld_q;
	logic [16:0] u_s1, t_s1;
	logic [33:0] uu_s2, ut_s2, tt_s2;
	logic [16:0] u_s2, t_s2;
	logic [24:0] w_s3 [4];
	logic signed [COORD_WIDTH-1:0] cx_s1 [4], cy_s1 [4], cx_s2 [4], cy_s2 [4],
		cx_s3 [4], cy_s3 [4];
	logic signed [AW-1:0] sx_s4, sy_s4;
	logic signed [COORD_WIDTH-1:0] px_q, py_q;

	function automatic logic signed [COORD_WIDTH-1:0] rnd_sat(
		input logic signed [AW-1:0] a);
		logic signed [AW-1:0] r;
		logic signed [AW-25:0] f;
		logic signed [AW-25:0] hi;
		logic signed [AW-25:0] lo;
		r  = a + $signed(AW'(24'h800000));
		f  = r[AW-1:24];
		hi = (AW-24)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
		lo = -hi - (AW-24)'(1);
		if (f > hi) return hi[COORD_WIDTH-1:0];
		if (f < lo) return lo[COORD_WIDTH-1:0];
		return f[COORD_WIDTH-1:0];
	endfunction

	function automatic logic [24:0] wr(input logic [51:0] raw);
		logic [51:0] s;
		s = raw + 52'h800000;
		return s[48:24];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[3:0], in_vld};
	end

	always_ff @(posedge clk) begin
		// stage 1: clamp t
		t_s1 <= (t > 17'd65536) ? 17'd65536 : t;
		u_s1 <= 17'd65536 - ((t > 17'd65536) ? 17'd65536 : t);
		for (int k = 0; k < 4; k++) begin
			cx_s2[k] <= cx_s1[k];
			cy_s2[k] <= cy_s1[k];
			cx_s3[k] <= cx_s2[k];
			cy_s3[k] <= cy_s2[k];
		end
		cx_s1[0] <= c0x; cx_s1[1] <= c1x; cx_s1[2] <= c2x; cx_s1[3] <= c3x;
		cy_s1[0] <= c0y; cy_s1[1] <= c1y; cy_s1[2] <= c2y; cy_s1[3] <= c3y;
		// stage 2: squares and cross product
		uu_s2 <= u_s1 * u_s1;
		ut_s2 <= u_s1 * t_s1;
		tt_s2 <= t_s1 * t_s1;
		u_s2  <= u_s1;
		t_s2  <= t_s1;
		// stage 3: rounded weights
		w_s3[0] <= wr(52'(uu_s2 * u_s2));
		w_s3[1] <= wr(52'(3 * 52'(uu_s2 * t_s2)));
		w_s3[2] <= wr(52'(3 * 52'(tt_s2 * u_s2)));
		w_s3[3] <= wr(52'(tt_s2 * t_s2));
		// stage 4: weighted sums
		sx_s4 <= AW'(cx_s3[0] * $signed({1'b0, w_s3[0]}))
			+ AW'(cx_s3[1] * $signed({1'b0, w_s3[1]}))
			+ AW'(cx_s3[2] * $signed({1'b0, w_s3[2]}))
			+ AW'(cx_s3[3] * $signed({1'b0, w_s3[3]}));
		sy_s4 <= AW'(cy_s3[0] * $signed({1'b0, w_s3[0]}))
			+ AW'(cy_s3[1] * $signed({1'b0, w_s3[1]}))
			+ AW'(cy_s3[2] * $signed({1'b0, w_s3[2]}))
			+ AW'(cy_s3[3] * $signed({1'b0, w_s3[3]}));
		// stage 5: round and saturate
		px_q <= rnd_sat(sx_s4);
		py_q <= rnd_sat(sy_s4);
	end

	assign out_vld = vld_q[4];
	assign px = px_q;
	assign py = py_q;
endmodule

// File: rtl/bezier_path_eval_nearest_t_top.sv
// ----------------------------------------------------------------------------
// bezier_path_eval_nearest_t_top: cubic Bezier path table with evaluation
// and nearest-sample search over a fixed number of steps.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         action index t point_* in_* out_*
//  config    cfg_valid/cfg_ready  cfg_index cfg_data
//  result    done (one cycle)     curve_x curve_y best_step status
//
// A load ends after the read state; an evaluate or a search runs the evaluator
// pipeline, which takes one sample per cycle.
// The control points live in one synchronous table, one entry per row;
// a segment reads two rows, one per cycle, through the single read port.
// Reset clears the sequencer and the config registers; the table holds no reset.
// Results cannot be stalled: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module bezier_path_eval_nearest_t_top #(
	parameter int MAX_POINTS  = bpe_pkg::MAX_POINTS_DEF,
	parameter int STEPS       = bpe_pkg::STEPS_DEF,
	parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      action,
	input  logic [5:0]                      index,
	input  logic [bpe_pkg::T_W-1:0]         t,
	input  logic signed [COORD_WIDTH-1:0]   point_x,
	input  logic signed [COORD_WIDTH-1:0]   point_y,
	input  logic signed [COORD_WIDTH-1:0]   in_x,
	input  logic signed [COORD_WIDTH-1:0]   in_y,
	input  logic signed [COORD_WIDTH-1:0]   out_x,
	input  logic signed [COORD_WIDTH-1:0]   out_y,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [0:0]                      cfg_index,
	input  logic [bpe_pkg::CNT_W-1:0]       cfg_data,
	output logic                            done,
	output logic signed [COORD_WIDTH-1:0]   curve_x,
	output logic signed [COORD_WIDTH-1:0]   curve_y,
	output logic [bpe_pkg::STEP_W-1:0]      best_step,
	output logic [bpe_pkg::STATUS_W-1:0]    status
);
	localparam int CW  = COORD_WIDTH;
	localparam int EW  = 6 * CW;
	localparam int SW  = $clog2(STEPS + 1);
	localparam int DW  = 2 * CW + 2;
	localparam int AIW = (MAX_POINTS > 64) ? 6 : $clog2(MAX_POINTS);

	bpe_pkg::state_t state_q, state_d;

	// one row per point: anchor x,y / in x,y / out x,y
	logic [EW-1:0] mem [MAX_POINTS];
	logic [EW-1:0] rd_data_q;
	logic [AIW-1:0] rd_addr;

	logic [bpe_pkg::CNT_W-1:0] count_q;
	logic closed_q;

	logic [1:0] act_q;
	logic [5:0] nxt_q;
	logic [bpe_pkg::T_W-1:0] t_q;
	logic signed [CW-1:0] qx_q, qy_q;
	logic [EW-1:0] row_a_q;
	logic [EW-1:0] row_b_q;
	logic rd_sel_q;

	logic [SW-1:0] step_q, out_step_q;
	logic [bpe_pkg::T_W-1:0] ts_q;
	logic issue;
	logic [1:0] done_q;

	logic ev_vld;
	logic signed [CW-1:0] ev_x, ev_y;
	logic [DW-1:0] best_d_q;
	logic have_q;

	logic signed [CW-1:0] rx_q, ry_q;
	logic [SW-1:0] rbest_q;
	logic [1:0] stat_q;
	logic fin_q;

	logic [bpe_pkg::CNT_W-1:0] cnt_eff;
	logic idx_bad, idx_last;

	// step tag of each sample in the evaluator
	logic [SW-1:0] tag_q [5];
	logic last_out;

	logic [SW+16:0] rem_sum, rem_nx;

	logic [CW:0] adx, ady;
	logic [DW-1:0] dist_sq;

	assign cnt_eff  = (count_q > bpe_pkg::CNT_W'(MAX_POINTS))
		? bpe_pkg::CNT_W'(MAX_POINTS) : count_q;
	assign idx_bad  = {1'b0, index} >= cnt_eff;
	assign idx_last = ({1'b0, index} + 7'd1) == cnt_eff;

	assign busy      = (state_q != bpe_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			closed_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bpe_pkg::REG_POINT_COUNT: count_q  <= cfg_data;
				bpe_pkg::REG_CLOSED:      closed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// table write and registered read
	always_ff @(posedge clk) begin
		if (start && !busy && action == bpe_pkg::ACT_LOAD && {1'b0, index} < 7'(MAX_POINTS))
			mem[AIW'(index)] <= {out_y, out_x, in_y, in_x, point_y, point_x};
		rd_data_q <= mem[rd_addr];
	end

	// read the start row in the accept cycle, the next row in the cycle after
	assign rd_addr = rd_sel_q ? AIW'(nxt_q) : AIW'(index);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpe_pkg::S_IDLE:  if (start) state_d = bpe_pkg::S_RD;
			bpe_pkg::S_RD:    state_d = (act_q == bpe_pkg::ACT_EVAL ||
				act_q == bpe_pkg::ACT_SEARCH) && stat_q == bpe_pkg::ST_OK
				? bpe_pkg::S_LATCH : bpe_pkg::S_DONE;
			bpe_pkg::S_LATCH: state_d = bpe_pkg::S_RUN;
			bpe_pkg::S_RUN:   if (act_q == bpe_pkg::ACT_EVAL ||
				step_q == SW'(STEPS - 1)) state_d = bpe_pkg::S_DRAIN;
			bpe_pkg::S_DRAIN: if (fin_q) state_d = bpe_pkg::S_DONE;
			bpe_pkg::S_DONE:  state_d = bpe_pkg::S_IDLE;
			default:          state_d = bpe_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		issue = (state_q == bpe_pkg::S_RUN);
	end

	assign last_out = (act_q == bpe_pkg::ACT_EVAL) || (out_step_q == SW'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bpe_pkg::S_IDLE;
			rd_sel_q <= 1'b0;
			done_q   <= '0;
			fin_q    <= 1'b0;
			have_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_sel_q <= (state_q == bpe_pkg::S_IDLE && start);
			done_q   <= {done_q[0], issue && state_d == bpe_pkg::S_DRAIN};
			if (state_q == bpe_pkg::S_LATCH) fin_q <= 1'b0;
			// set when the last sample leaves the evaluator
			else if (ev_vld && done_q == 2'b00 && state_q == bpe_pkg::S_DRAIN
				&& last_out) fin_q <= 1'b1;
			if (state_q == bpe_pkg::S_LATCH) have_q <= 1'b0;
			else if (ev_vld) have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bpe_pkg::S_IDLE && start) begin
			act_q  <= action;
			nxt_q  <= idx_last ? 6'd0 : index + 6'd1;
			t_q    <= t;
			qx_q   <= point_x;
			qy_q   <= point_y;
			stat_q <= (action == bpe_pkg::ACT_LOAD)
				? ({1'b0, index} < 7'(MAX_POINTS) ? bpe_pkg::ST_OK : bpe_pkg::ST_RANGE)
				: (action == bpe_pkg::ACT_EVAL || action == bpe_pkg::ACT_SEARCH)
				? (idx_bad ? bpe_pkg::ST_RANGE
					: (idx_last && !closed_q) ? bpe_pkg::ST_NOSEG : bpe_pkg::ST_OK)
				: bpe_pkg::ST_OK;
			rx_q    <= '0;
			ry_q    <= '0;
			rbest_q <= '0;
		end
		if (state_q == bpe_pkg::S_RD) row_a_q <= rd_data_q;
		if (state_q == bpe_pkg::S_LATCH) begin
			step_q <= SW'(1);
		end else if (issue) begin
			step_q <= step_q + SW'(1);
		end
		tag_q[0] <= step_q;
		for (int k = 1; k < 5; k++) tag_q[k] <= tag_q[k-1];
		// best-so-far update at the evaluator output
		if (ev_vld && !fin_q) begin
			if (!have_q || dist_sq < best_d_q) begin
				best_d_q <= dist_sq;
				rx_q     <= ev_x;
				ry_q     <= ev_y;
				rbest_q  <= (act_q == bpe_pkg::ACT_EVAL) ? '0 : out_step_q;
			end
		end
	end
	assign out_step_q = tag_q[4];

	// t for a step: running quotient of (s*65536 + STEPS/2) / STEPS
	logic [bpe_pkg::T_W-1:0] ts_d;
	logic [SW+16:0] rem_q;
	always_ff @(posedge clk) begin
		if (state_q == bpe_pkg::S_LATCH) begin
			ts_q  <= bpe_pkg::T_W'((65536 + STEPS / 2) / STEPS);
			rem_q <= (SW+17)'((65536 + STEPS / 2) % STEPS);
		end else if (issue) begin
			ts_q  <= ts_d;
			rem_q <= rem_nx;
		end
	end
	// advance by 65536/STEPS with carry of the remainder
	localparam int QINC = 65536 / STEPS;
	localparam int RINC = 65536 % STEPS;
	assign rem_sum = rem_q + (SW+17)'(RINC);
	assign rem_nx  = (rem_sum >= (SW+17)'(STEPS)) ? rem_sum - (SW+17)'(STEPS) : rem_sum;
	assign ts_d    = ts_q + bpe_pkg::T_W'(QINC)
		+ bpe_pkg::T_W'(rem_sum >= (SW+17)'(STEPS));

	logic [EW-1:0] row_b;
	assign row_b = rd_data_q;

	bpe_eval #(.COORD_WIDTH(CW)) u_eval (
		.clk(clk), .arst_n(arst_n),
		.in_vld(issue),
		.t(act_q == bpe_pkg::ACT_EVAL ? t_q : ts_q),
		.c0x(row_a_q[CW-1:0]), .c0y(row_a_q[2*CW-1:CW]),
		.c1x(row_a_q[5*CW-1:4*CW]), .c1y(row_a_q[6*CW-1:5*CW]),
		.c2x(row_b_q[3*CW-1:2*CW]), .c2y(row_b_q[4*CW-1:3*CW]),
		.c3x(row_b_q[CW-1:0]), .c3y(row_b_q[2*CW-1:CW]),
		.out_vld(ev_vld), .px(ev_x), .py(ev_y)
	);
	always_ff @(posedge clk) if (state_q == bpe_pkg::S_LATCH) row_b_q <= row_b;

	// squared distance of the current sample
	always_comb begin
		adx  = (ev_x >= qx_q) ? (CW+1)'({ev_x[CW-1], ev_x} - {qx_q[CW-1], qx_q})
			: (CW+1)'({qx_q[CW-1], qx_q} - {ev_x[CW-1], ev_x});
		ady  = (ev_y >= qy_q) ? (CW+1)'({ev_y[CW-1], ev_y} - {qy_q[CW-1], qy_q})
			: (CW+1)'({qy_q[CW-1], qy_q} - {ev_y[CW-1], ev_y});
		dist_sq = DW'(adx * adx) + DW'(ady * ady);
	end

	assign done      = (state_q == bpe_pkg::S_DONE);
	assign curve_x   = (stat_q == bpe_pkg::ST_OK) ? rx_q : '0;
	assign curve_y   = (stat_q == bpe_pkg::ST_OK) ? ry_q : '0;
	assign best_step = (stat_q == bpe_pkg::ST_OK) ? bpe_pkg::STEP_W'(rbest_q) : '0;
	assign status    = stat_q;
endmodule

// File: rtl/bpe_check.sv
// ----------------------------------------------------------------------------
// bpe_check: port-level checks for the path evaluator
// ----------------------------------------------------------------------------
module bpe_check (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3) else $error("bad status");
endmodule

bind bezier_path_eval_nearest_t_top bpe_check u_check (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .status(status)
);

// File: tb/sv/bezier_path_eval_nearest_t_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_path_eval_nearest_t_top_tb: self-checking bench for the path evaluator
// Loads the control point table, then drives directed and random load,
// evaluate and search commands under several table sizes and open/closed
// settings. A local Bernstein predictor computes each expected beat, and
// the done strobe is compared field by field against it.
// ----------------------------------------------------------------------------
module bezier_path_eval_nearest_t_top_tb;

	localparam int NPTS  = 64;
	localparam int NSTEP = 1000;
	localparam int CW    = 24;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		logic [1:0]                    action;
		logic [5:0]                    index;
		logic [bpe_pkg::T_W-1:0]       t;
		logic signed [CW-1:0]          px, py, ix, iy, ox, oy;
	} command_t;

	typedef struct {
		logic [CW-1:0]                 cx, cy;
		logic [bpe_pkg::STEP_W-1:0]    step;
		logic [bpe_pkg::STATUS_W-1:0]  stat;
	} curve_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = bpe_pkg::ACT_LOAD;
	logic [5:0] index = '0;
	logic [bpe_pkg::T_W-1:0] t = '0;
	logic signed [CW-1:0] point_x = '0, point_y = '0;
	logic signed [CW-1:0] in_x = '0, in_y = '0, out_x = '0, out_y = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = bpe_pkg::REG_POINT_COUNT;
	logic [bpe_pkg::CNT_W-1:0] cfg_data = '0;
	logic done;
	logic signed [CW-1:0] curve_x, curve_y;
	logic [bpe_pkg::STEP_W-1:0] best_step;
	logic [bpe_pkg::STATUS_W-1:0] status;

	// predictor copy of the table and the registers
	logic signed [CW-1:0] anc_x[NPTS], anc_y[NPTS];
	logic signed [CW-1:0] hin_x[NPTS], hin_y[NPTS];
	logic signed [CW-1:0] hout_x[NPTS], hout_y[NPTS];
	int unsigned model_count = 0;
	bit model_closed = 1'b0;

	curve_beat_t pending_curves[$];
	int mismatch_count = 0;
	int idle_pct = 0;

	bezier_path_eval_nearest_t_top DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bernstein point of the segment a -> b at Q1.16 t, rounded and saturated
	task automatic bezier_point(input int a, input int b, input longint unsigned tq,
			output logic signed [CW-1:0] rx, output logic signed [CW-1:0] ry);
		longint unsigned u, w[4];
		longint sx, sy;
		longint lim;
		u = 65536 - tq;
		w[0] = (u * u * u + (64'd1 << 23)) >> 24;
		w[1] = (3 * u * u * tq + (64'd1 << 23)) >> 24;
		w[2] = (3 * u * tq * tq + (64'd1 << 23)) >> 24;
		w[3] = (tq * tq * tq + (64'd1 << 23)) >> 24;
		sx = longint'(anc_x[a]) * longint'(w[0]) + longint'(hout_x[a]) * longint'(w[1])
			+ longint'(hin_x[b]) * longint'(w[2]) + longint'(anc_x[b]) * longint'(w[3]);
		sy = longint'(anc_y[a]) * longint'(w[0]) + longint'(hout_y[a]) * longint'(w[1])
			+ longint'(hin_y[b]) * longint'(w[2]) + longint'(anc_y[b]) * longint'(w[3]);
		sx = (sx + (64'sd1 <<< 23)) >>> 24;
		sy = (sy + (64'sd1 <<< 23)) >>> 24;
		lim = (64'sd1 <<< (CW - 1)) - 1;
		if (sx > lim) sx = lim;
		if (sx < -lim - 1) sx = -lim - 1;
		if (sy > lim) sy = lim;
		if (sy < -lim - 1) sy = -lim - 1;
		rx = sx[CW-1:0];
		ry = sy[CW-1:0];
	endtask

	// work out the beat a command produces and update the table copy
	task automatic predict_curve(input command_t c);
		curve_beat_t r;
		int cnt, nxt;
		longint unsigned tq, ts, d, bestd, dx, dy;
		logic signed [CW-1:0] qx, qy;
		r = '{default: '0};
		cnt = (model_count > NPTS) ? NPTS : model_count;
		if (c.action == bpe_pkg::ACT_LOAD) begin
			anc_x[c.index] = c.px;  anc_y[c.index] = c.py;
			hin_x[c.index] = c.ix;  hin_y[c.index] = c.iy;
			hout_x[c.index] = c.ox; hout_y[c.index] = c.oy;
		end else if (c.action == bpe_pkg::ACT_EVAL || c.action == bpe_pkg::ACT_SEARCH) begin
			if (c.index >= cnt) begin
				r.stat = bpe_pkg::ST_RANGE;
			end else if (c.index + 1 == cnt && !model_closed) begin
				r.stat = bpe_pkg::ST_NOSEG;
			end else begin
				nxt = (c.index + 1 == cnt) ? 0 : c.index + 1;
				if (c.action == bpe_pkg::ACT_EVAL) begin
					tq = (c.t > 65536) ? 65536 : c.t;
					bezier_point(c.index, nxt, tq, qx, qy);
					r.cx = qx;
					r.cy = qy;
				end else begin
					bestd = 0;
					for (int s = 1; s < NSTEP; s++) begin
						ts = (longint'(s) * 65536 + NSTEP / 2) / NSTEP;
						bezier_point(c.index, nxt, ts, qx, qy);
						dx = (longint'(qx) >= longint'(c.px)) ? longint'(qx) - longint'(c.px)
							: longint'(c.px) - longint'(qx);
						dy = (longint'(qy) >= longint'(c.py)) ? longint'(qy) - longint'(c.py)
							: longint'(c.py) - longint'(qy);
						d = dx * dx + dy * dy;
						// strict compare keeps the first step of a tie
						if (s == 1 || d < bestd) begin
							bestd = d;
							r.step = bpe_pkg::STEP_W'(s);
							r.cx = qx;
							r.cy = qy;
						end
					end
				end
			end
		end
		pending_curves.push_back(r);
	endtask

	// send one command beat: idle at random, hold until busy drops, then drop start
	task automatic send_command(input command_t c);
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		@(negedge clk);
		start = 1'b1;
		action = c.action; index = c.index; t = c.t;
		point_x = c.px; point_y = c.py;
		in_x = c.ix; in_y = c.iy; out_x = c.ox; out_y = c.oy;
		do @(posedge clk); while (busy);
		predict_curve(c);
		@(negedge clk);
		start = 1'b0;
	endtask

	// hold off until every expected beat is back and the block is quiet
	task automatic drain;
		wait (pending_curves.size() == 0);
		repeat (12) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] ri, input logic [bpe_pkg::CNT_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = ri;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (ri == bpe_pkg::REG_POINT_COUNT) model_count = val;
		else model_closed = val[0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_path(input int cnt, input bit cl);
		drain();
		write_reg(bpe_pkg::REG_POINT_COUNT, cnt[bpe_pkg::CNT_W-1:0]);
		write_reg(bpe_pkg::REG_CLOSED, bpe_pkg::CNT_W'(cl));
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(3))
			0: rand_coord = CW'($urandom_range(255) - 128);
			1: rand_coord = CW'($urandom_range(65535) - 32768);
			default: rand_coord = CW'($urandom);
		endcase
	endfunction

	function automatic command_t make_cmd(input logic [1:0] a, input int idx,
			input int tv);
		command_t c;
		c.action = a;
		c.index = 6'(idx);
		c.t = bpe_pkg::T_W'(tv);
		c.px = rand_coord(); c.py = rand_coord();
		c.ix = rand_coord(); c.iy = rand_coord();
		c.ox = rand_coord(); c.oy = rand_coord();
		return c;
	endfunction

	// fill every entry so no evaluation ever reads an unwritten row
	task automatic test_fill_table;
		for (int i = 0; i < NPTS; i++) send_command(make_cmd(bpe_pkg::ACT_LOAD, i, $urandom));
	endtask

	task automatic test_directed;
		command_t c;
		set_path(0, 0);
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 0, 0));     // empty table: range
		send_command(make_cmd(ACT_NONE, 5, $urandom));       // unused action
		set_path(4, 0);
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 0, 0));
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 1, 65536));
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 2, 131071)); // t above one clamps
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 3, 32768));  // open last point
		send_command(make_cmd(bpe_pkg::ACT_SEARCH, 3, 0));
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 4, 100));    // past the count
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 63, 100));
		// extreme coordinates on entries 0 and 1
		c = make_cmd(bpe_pkg::ACT_LOAD, 0, 0);
		c.px = {1'b0, {(CW-1){1'b1}}}; c.py = {1'b1, {(CW-1){1'b0}}};
		c.ox = c.px; c.oy = c.py; c.ix = c.py; c.iy = c.px;
		send_command(c);
		c.index = 1;
		send_command(c);
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 0, 21845));
		send_command(make_cmd(bpe_pkg::ACT_SEARCH, 0, 0));
		set_path(4, 1);
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 3, 40000));  // wraps to entry 0
		// flat segment: every step ties, the first wins
		c = make_cmd(bpe_pkg::ACT_LOAD, 2, 0);
		c.px = 24'sd1000; c.py = -24'sd1000;
		c.ix = c.px; c.iy = c.py; c.ox = c.px; c.oy = c.py;
		send_command(c);
		c.index = 3;
		send_command(c);
		send_command(make_cmd(bpe_pkg::ACT_SEARCH, 2, 0));
		set_path(1, 1);                                      // single closed point
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 0, 50000));
		send_command(make_cmd(bpe_pkg::ACT_SEARCH, 0, 0));
		set_path(127, 1);                                    // above the table acts as full
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 63, 65535));
		set_path(64, 0);
		send_command(make_cmd(bpe_pkg::ACT_EVAL, 63, 1));
	endtask

	// random commands in phases, each with its own table setting
	task automatic test_random(input int phases, input int per_phase);
		int cnt, r, idx;
		logic [1:0] a;
		for (int p = 0; p < phases; p++) begin
			case (p % 4)
				0: cnt = 64;
				1: cnt = $urandom_range(127);
				2: cnt = $urandom_range(1, 3);
				default: cnt = $urandom_range(2, 64);
			endcase
			set_path(cnt, 1'($urandom_range(1)));
			for (int k = 0; k < per_phase; k++) begin
				r = $urandom_range(99);
				if (r < 25) a = bpe_pkg::ACT_LOAD;
				else if (r < 70) a = bpe_pkg::ACT_EVAL;
				else if (r < 92) a = bpe_pkg::ACT_SEARCH;
				else a = ACT_NONE;
				if (cnt > 0 && $urandom_range(9) < 8)
					idx = $urandom_range(((cnt > NPTS) ? NPTS : cnt) - 1);
				else
					idx = $urandom_range(63);
				send_command(make_cmd(a, idx, $urandom_range(1) ? $urandom_range(65536)
					: $urandom));
			end
		end
	endtask

	// compare each done beat with the oldest expectation
	always @(posedge clk) begin
		curve_beat_t e;
		if (arst_n && done) begin
			if (pending_curves.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected beat: x=%h y=%h step=%0d st=%0d",
						curve_x, curve_y, best_step, status);
			end else begin
				e = pending_curves.pop_front();
				if (e.cx !== curve_x || e.cy !== curve_y || e.step !== best_step
						|| e.stat !== status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp x=%h y=%h step=%0d st=%0d, got x=%h y=%h step=%0d st=%0d",
							e.cx, e.cy, e.step, e.stat, curve_x, curve_y, best_step, status);
				end
			end
		end
	end

	initial begin
		#30000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_pct = 6;
		test_fill_table();
		test_directed();
		test_random(3, 57);
		idle_pct = 72;
		test_random(3, 57);
		idle_pct = 0;
		test_random(3, 57);
		// hold off the sender until every beat is home, then finish
		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_curves.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
